### sv/krg_pkg.sv
// Shared types, codes and generator step functions for the KISS random generator.
`timescale 1ns / 1ps

package krg_pkg;

    // Field widths
    localparam int WORD_BITS   = 64;
    localparam int VAL_BITS    = 32;
    localparam int SPAN_BITS   = VAL_BITS + 1;
    localparam int REQ_BITS    = 2;
    localparam int IN_DATA_W   = 2 * VAL_BITS;
    localparam int OUT_DATA_W  = WORD_BITS + VAL_BITS;
    localparam int DIV_CNT_W   = $clog2(WORD_BITS);

    // Request codes
    localparam logic [REQ_BITS-1:0] REQ_RAW   = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_RANGE = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_DICE  = 2'd2;

    // Generator constants
    localparam logic [WORD_BITS-1:0] LCG_MULT  = 64'd69069;
    localparam logic [WORD_BITS-1:0] LCG_INC   = 64'd1;
    localparam int                   XS_SHL_A  = 13;
    localparam int                   XS_SHR    = 17;
    localparam int                   XS_SHL_B  = 5;
    localparam int                   CARRY_SHR = 30;
    localparam logic [WORD_BITS-1:0] RESET_SEED = 64'd1;

    // Job queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Generator state
    typedef struct packed {
        logic [WORD_BITS-1:0] lcg;
        logic [WORD_BITS-1:0] xs;
        logic [WORD_BITS-1:0] lag;
        logic [WORD_BITS-1:0] sum;
        logic [WORD_BITS-1:0] carry;
    } t_gen_state;

    // Classified request handed from front to back
    typedef struct packed {
        logic                 bad;
        logic                 raw_only;
        logic [SPAN_BITS-1:0] span;
        logic [VAL_BITS-1:0]  offset;
    } t_job;

    // Seed load: zero acts as one
    function automatic t_gen_state krg_load(input logic [WORD_BITS-1:0] seed);
        t_gen_state           st;
        logic [WORD_BITS-1:0] s;
        s        = (seed == '0) ? RESET_SEED : seed;
        st.lcg   = s | 64'd1;
        st.xs    = s | 64'd2;
        st.lag   = s | 64'd4;
        st.sum   = s | 64'd8;
        st.carry = '0;
        return st;
    endfunction

    // One generator step
    function automatic t_gen_state krg_draw(input t_gen_state cur);
        t_gen_state           nx;
        logic [WORD_BITS-1:0] x;
        logic [WORD_BITS-1:0] partial;
        x        = cur.xs;
        x        = x ^ (x << XS_SHL_A);
        x        = x ^ (x >> XS_SHR);
        x        = x ^ (x << XS_SHL_B);
        partial  = (cur.lag >> 2) + (cur.sum >> 3) + (cur.carry >> 2);
        nx.lcg   = cur.lcg * LCG_MULT + LCG_INC;
        nx.xs    = x;
        nx.sum   = cur.sum + cur.sum + cur.lag + cur.carry;
        nx.lag   = cur.sum;
        nx.carry = partial >> CARRY_SHR;
        return nx;
    endfunction

    // Output word of the state left by a step
    function automatic logic [WORD_BITS-1:0] krg_word(input t_gen_state st);
        return st.lcg + st.xs + st.sum;
    endfunction

endpackage

### sv/kiss_random_generator.sv
// Top level of the 64-bit KISS random generator.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request type
//   (raw word, signed range draw, dice draw), tdata carries range_low and
//   range_high. Each request yields exactly one result transaction on the
//   m_axis channel: tdata holds the raw word and the ranged value, tuser
//   flags a rejected request (which leaves the generator state untouched).
//   The seed register is written with i_cfg_wr_en / i_cfg_wr_data while no
//   request is outstanding; the write loads the state and discards a draw.
// Processing:
//   Range and dice results pass through a 64-step radix-2 remainder loop;
//   raw draws and rejected requests skip it. The back end works on one
//   request at a time, so it takes a new job from the queue only after
//   the last result has gone into the result register.
// Reset and stalls:
//   Reset loads seed 1 plus one discarded draw and empties the job queue.
//   A stalled receiver holds the result register; up to two more requests
//   are queued before s_axis tready drops.
`timescale 1ns / 1ps

module kiss_random_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [krg_pkg::WORD_BITS-1:0]    i_cfg_wr_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [31:0] range_low, [63:32] range_high
    input  logic [krg_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] req_type
    input  logic [krg_pkg::REQ_BITS-1:0]     i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [63:0] raw_word, [95:64] ranged_value
    output logic [krg_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // [0] bad_request
    output logic                             o_m_axis_tuser
);
    import krg_pkg::*;

    t_job w_wr_job;
    t_job w_rd_job;
    logic w_wr_en;
    logic w_full;
    logic w_rd_en;
    logic w_empty;

    krg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (w_full),
        .o_q_wr_en       (w_wr_en),
        .o_q_wr_job      (w_wr_job)
    );

    krg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_wr_en),
        .i_wr_job (w_wr_job),
        .o_full   (w_full),
        .i_rd_en  (w_rd_en),
        .o_rd_job (w_rd_job),
        .o_empty  (w_empty)
    );

    krg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_q_empty       (w_empty),
        .i_q_job         (w_rd_job),
        .o_q_rd_en       (w_rd_en),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

### sv/krg_front.sv
// Front end: takes request transactions and classifies them into jobs.
`timescale 1ns / 1ps

module krg_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [krg_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input  logic [krg_pkg::REQ_BITS-1:0]     i_s_axis_tuser,
    input  logic                             i_q_full,
    output logic                             o_q_wr_en,
    output krg_pkg::t_job                    o_q_wr_job
);
    import krg_pkg::*;

    logic [VAL_BITS-1:0]  w_lo;
    logic [VAL_BITS-1:0]  w_hi;
    logic [SPAN_BITS-1:0] w_range_span;
    t_job                 w_job;
    logic                 r_seen_reset;

    assign w_lo = i_s_axis_tdata[VAL_BITS-1:0];
    assign w_hi = i_s_axis_tdata[IN_DATA_W-1:VAL_BITS];

    // Exact span high - low + 1 in 33 bits
    assign w_range_span = {w_hi[VAL_BITS-1], w_hi} - {w_lo[VAL_BITS-1], w_lo}
                          + SPAN_BITS'(1);

    // Classify by request type
    always_comb begin
        w_job.bad      = 1'b0;
        w_job.raw_only = 1'b0;
        w_job.span     = '0;
        w_job.offset   = '0;
        case (i_s_axis_tuser)
            REQ_RAW: begin
                w_job.raw_only = 1'b1;
            end
            REQ_RANGE: begin
                w_job.bad    = ($signed(w_hi) <= $signed(w_lo));
                w_job.span   = w_range_span;
                w_job.offset = w_lo;
            end
            REQ_DICE: begin
                w_job.bad    = ($signed(w_hi) < $signed(32'sd1));
                w_job.span   = {1'b0, w_hi};
                w_job.offset = VAL_BITS'(1);
            end
            default: begin
                w_job.bad = 1'b1;
            end
        endcase
    end

    // Hold off intake during reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_reset <= 1'b0;
        end else begin
            r_seen_reset <= 1'b1;
        end
    end

    assign o_s_axis_tready = r_seen_reset && !i_q_full;
    assign o_q_wr_en       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_wr_job      = w_job;

endmodule

### sv/krg_queue.sv
// Two-entry job queue between the front end and the draw engine.
`timescale 1ns / 1ps

module krg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  krg_pkg::t_job i_wr_job,
    output logic          o_full,
    input  logic          i_rd_en,
    output krg_pkg::t_job o_rd_job,
    output logic          o_empty
);
    import krg_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full   = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign w_push   = i_wr_en && !o_full;
    assign w_pop    = i_rd_en && !o_empty;
    assign o_rd_job = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### sv/krg_back.sv
// Draw engine: generator state, seed load, radix-2 remainder and result register.
`timescale 1ns / 1ps

module krg_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [krg_pkg::WORD_BITS-1:0]     i_cfg_wr_data,
    input  logic                              i_q_empty,
    input  krg_pkg::t_job                     i_q_job,
    output logic                              o_q_rd_en,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [krg_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                              o_m_axis_tuser
);
    import krg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WORD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    t_gen_state            r_gen;
    t_gen_state            w_gen_base;
    t_gen_state            w_gen_next;
    t_gen_state            w_gen_reset;
    logic                  w_draw;
    t_job                  r_job;
    logic [WORD_BITS-1:0]  r_word;
    logic [WORD_BITS-1:0]  r_dividend;
    logic [SPAN_BITS-1:0]  r_rem;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [SPAN_BITS:0]    w_trial;
    logic [SPAN_BITS:0]    w_trial_sub;
    logic                  w_out_free;
    logic                  r_out_valid;
    logic [WORD_BITS-1:0]  r_out_word;
    logic [VAL_BITS-1:0]   r_out_val;
    logic                  r_out_bad;

    // Control: pop a job when idle; a good job advances the generator
    assign o_q_rd_en  = r_state[0] && !i_q_empty;
    assign w_draw     = o_q_rd_en && !i_q_job.bad;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_q_rd_en) begin
                    n_state = i_q_job.bad ? ST_FIN : ST_WORD;
                end
            end
            ST_WORD: n_state = r_job.raw_only ? ST_FIN : ST_DIV;
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Generator: one step unit shared by seed load and draws
    assign w_gen_reset = krg_draw(krg_load(RESET_SEED));
    assign w_gen_base  = i_cfg_wr_en ? krg_load(i_cfg_wr_data) : r_gen;
    assign w_gen_next  = krg_draw(w_gen_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= w_gen_reset;
        end else if (i_cfg_wr_en || w_draw) begin
            r_gen <= w_gen_next;
        end
    end

    // Restoring remainder step: one dividend bit per cycle
    assign w_trial     = {r_rem, r_dividend[WORD_BITS-1]};
    assign w_trial_sub = w_trial - {1'b0, r_job.span};

    always_ff @(posedge i_clk) begin
        if (o_q_rd_en) begin
            r_job <= i_q_job;
        end
        case (r_state)
            ST_WORD: begin
                r_word     <= krg_word(r_gen);
                r_dividend <= krg_word(r_gen);
                r_rem      <= '0;
                r_cnt      <= DIV_CNT_W'(WORD_BITS - 1);
            end
            ST_DIV: begin
                r_dividend <= r_dividend << 1;
                r_cnt      <= r_cnt - DIV_CNT_W'(1);
                if (!w_trial_sub[SPAN_BITS]) begin
                    r_rem <= w_trial_sub[SPAN_BITS-1:0];
                end else begin
                    r_rem <= w_trial[SPAN_BITS-1:0];
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state[3] && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state[3] && w_out_free) begin
            r_out_bad <= r_job.bad;
            if (r_job.bad) begin
                r_out_word <= '0;
                r_out_val  <= '0;
            end else if (r_job.raw_only) begin
                r_out_word <= r_word;
                r_out_val  <= '0;
            end else begin
                r_out_word <= r_word;
                r_out_val  <= r_rem[VAL_BITS-1:0] + r_job.offset;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_val, r_out_word};
    assign o_m_axis_tuser  = r_out_bad;

endmodule

### sv/krg_checker.sv
// Port-level checks on the KISS random generator, bound to the top level.
`timescale 1ns / 1ps

module krg_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [krg_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input logic                             o_m_axis_tuser
);
    import krg_pkg::*;

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A result waits until taken
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // A rejected request carries no draw
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("rejected request with nonzero data");

endmodule

bind kiss_random_generator krg_checker u_krg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### sim/kiss_random_generator_test.sv
// Self-checking testbench for the KISS random generator: seeds, draw modes and flow control.
`timescale 1ns / 1ps

module kiss_random_generator_test;

    import krg_pkg::*;

    // Request code with no meaning in the block: always rejected
    localparam logic [REQ_BITS-1:0] REQ_INVALID = 2'd3;

    localparam logic [VAL_BITS-1:0] MIN32 = 32'h8000_0000;
    localparam logic [VAL_BITS-1:0] MAX32 = 32'h7fff_ffff;

    localparam int IDLE_PCT    = 13;
    localparam int HOLD_CYCLES = 300;
    localparam int END_WAIT    = 100;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        logic [REQ_BITS-1:0] kind;
        logic [VAL_BITS-1:0] low;
        logic [VAL_BITS-1:0] high;
    } t_draw_request;

    typedef struct packed {
        logic [WORD_BITS-1:0] raw;
        logic [VAL_BITS-1:0]  ranged;
        logic                 bad;
    } t_draw_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [WORD_BITS-1:0]  i_cfg_wr_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [REQ_BITS-1:0]   i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;

    // Predicted generator state
    logic [WORD_BITS-1:0] gen_cong;
    logic [WORD_BITS-1:0] gen_shift;
    logic [WORD_BITS-1:0] gen_lag;
    logic [WORD_BITS-1:0] gen_acc;
    logic [WORD_BITS-1:0] gen_carry;

    t_draw_result expected_draws[$];
    int           items_sent = 0;
    int           results_done = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    logic         idle_on = 1'b1;
    logic         hold_toggle = 1'b0;
    logic         hold_seen = 1'b0;
    int           hold_left = 0;

    kiss_random_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // One generator step: congruential + xorshift + add-with-carry
    function automatic logic [WORD_BITS-1:0] step_generator();
        logic [WORD_BITS-1:0] part;
        logic [WORD_BITS-1:0] next_acc;
        gen_cong  = gen_cong * 64'd69069 + 64'd1;
        gen_shift = gen_shift ^ (gen_shift << 13);
        gen_shift = gen_shift ^ (gen_shift >> 17);
        gen_shift = gen_shift ^ (gen_shift << 5);
        part      = (gen_lag >> 2) + (gen_acc >> 3) + (gen_carry >> 2);
        next_acc  = gen_acc + gen_acc + gen_lag + gen_carry;
        gen_lag   = gen_acc;
        gen_acc   = next_acc;
        gen_carry = part >> 30;
        return gen_cong + gen_shift + gen_acc;
    endfunction

    // Seed load; zero seeds like one, first draw thrown away
    function automatic void reseed_generator(input logic [WORD_BITS-1:0] seed);
        logic [WORD_BITS-1:0] s;
        s         = (seed == '0) ? 64'd1 : seed;
        gen_cong  = s | 64'd1;
        gen_shift = s | 64'd2;
        gen_lag   = s | 64'd4;
        gen_acc   = s | 64'd8;
        gen_carry = '0;
        void'(step_generator());
    endfunction

    // Expected result of one request; rejected requests leave the state alone
    function automatic t_draw_result predict_draw(input t_draw_request rq);
        t_draw_result         res;
        logic [WORD_BITS-1:0] word;
        logic [WORD_BITS-1:0] span;
        longint               lo_v;
        longint               hi_v;
        res  = '0;
        lo_v = longint'($signed(rq.low));
        hi_v = longint'($signed(rq.high));
        case (rq.kind)
            REQ_RAW: begin
                res.raw = step_generator();
            end
            REQ_RANGE: begin
                if (hi_v > lo_v) begin
                    span       = 64'(hi_v - lo_v + 1);
                    word       = step_generator();
                    res.raw    = word;
                    res.ranged = 32'((word % span) + 64'(lo_v));
                end else begin
                    res.bad = 1'b1;
                end
            end
            REQ_DICE: begin
                if (hi_v >= 1) begin
                    span       = 64'(hi_v);
                    word       = step_generator();
                    res.raw    = word;
                    res.ranged = 32'((word % span) + 64'd1);
                end else begin
                    res.bad = 1'b1;
                end
            end
            default: begin
                res.bad = 1'b1;
            end
        endcase
        return res;
    endfunction

    function automatic t_draw_request make_request(input logic [REQ_BITS-1:0] kind,
                                                   input logic [VAL_BITS-1:0] low,
                                                   input logic [VAL_BITS-1:0] high);
        t_draw_request rq;
        rq.kind = kind;
        rq.low  = low;
        rq.high = high;
        return rq;
    endfunction

    // Random request: mostly valid draws, small spans favored, some rejects
    function automatic t_draw_request random_request();
        t_draw_request rq;
        int unsigned   pick;
        longint        width;
        longint        lo_v;
        pick    = $urandom_range(0, 99);
        rq.low  = $urandom;
        rq.high = $urandom;
        if (pick < 22) begin
            rq.kind = REQ_RAW;
        end else if (pick < 60) begin
            rq.kind = REQ_RANGE;
            case ($urandom_range(0, 3))
                0: begin
                end
                3: begin
                    rq.low  = MIN32 + $urandom_range(0, 3);
                    rq.high = MAX32 - $urandom_range(0, 3);
                end
                default: begin
                    width = $urandom_range(1, 1000);
                    lo_v  = longint'($signed(rq.low));
                    if (lo_v > 64'sd2147483647 - width)
                        lo_v = 64'sd2147483647 - width;
                    rq.low  = 32'(lo_v);
                    rq.high = 32'(lo_v + width);
                end
            endcase
        end else if (pick < 92) begin
            rq.kind = REQ_DICE;
            case ($urandom_range(0, 4))
                3: rq.high[31] = 1'b0;
                4: rq.high[31] = 1'b1;
                default: rq.high = $urandom_range(1, 100);
            endcase
        end else begin
            rq.kind = REQ_INVALID;
        end
        return rq;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 40)
            $display("%0t: mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Send one request; called at a rising edge, returns at the accepting edge
    task automatic send_request(input t_draw_request rq);
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {rq.high, rq.low};
        i_s_axis_tuser  <= rq.kind;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        expected_draws.push_back(predict_draw(rq));
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (results_done != items_sent)
            @(posedge i_clk);
    endtask

    // Seed write; only while nothing is outstanding
    task automatic write_seed(input logic [WORD_BITS-1:0] seed);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= seed;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        reseed_generator(seed);
    endtask

    // Output side: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen       <= hold_toggle;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Result checker: compare each transaction against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_draw_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_done <= results_done + 1;
            if (expected_draws.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata[63:0], '0);
            end else begin
                want = expected_draws.pop_front();
                if (o_m_axis_tdata[63:0] !== want.raw)
                    report_mismatch("raw_word", o_m_axis_tdata[63:0], want.raw);
                if (o_m_axis_tdata[95:64] !== want.ranged)
                    report_mismatch("ranged_value", 64'(o_m_axis_tdata[95:64]),
                                    64'(want.ranged));
                if (o_m_axis_tuser !== want.bad)
                    report_mismatch("bad_request", 64'(o_m_axis_tuser), 64'(want.bad));
            end
        end
    end

    // Field extremes, every mode and every reject case, on the reset seed
    task automatic test_directed_cases();
        t_draw_request cases[$];
        cases.push_back(make_request(REQ_RAW, '0, '0));
        cases.push_back(make_request(REQ_RAW, '1, '1));
        cases.push_back(make_request(REQ_RANGE, MIN32, MAX32));
        cases.push_back(make_request(REQ_RANGE, 32'd0, 32'd1));
        cases.push_back(make_request(REQ_RANGE, '1, 32'd0));
        cases.push_back(make_request(REQ_RANGE, MIN32, MIN32 + 32'd1));
        cases.push_back(make_request(REQ_RANGE, MAX32 - 32'd1, MAX32));
        cases.push_back(make_request(REQ_RANGE, -32'sd1000, 32'sd1000));
        // high not above low
        cases.push_back(make_request(REQ_RANGE, 32'd5, 32'd5));
        cases.push_back(make_request(REQ_RANGE, 32'd10, -32'sd10));
        cases.push_back(make_request(REQ_RANGE, MAX32, MIN32));
        cases.push_back(make_request(REQ_DICE, '0, 32'd1));
        cases.push_back(make_request(REQ_DICE, '1, 32'd6));
        cases.push_back(make_request(REQ_DICE, MIN32, MAX32));
        // dice count below one
        cases.push_back(make_request(REQ_DICE, '0, 32'd0));
        cases.push_back(make_request(REQ_DICE, '0, '1));
        cases.push_back(make_request(REQ_DICE, MAX32, MIN32));
        // unknown request type
        cases.push_back(make_request(REQ_INVALID, '0, '0));
        cases.push_back(make_request(REQ_INVALID, '1, '1));
        cases.push_back(make_request(REQ_RAW, MIN32, MAX32));
        foreach (cases[i])
            send_request(cases[i]);
        wait_for_results();
    endtask

    // Seed extremes, including zero standing in for one
    task automatic test_seed_loads();
        logic [WORD_BITS-1:0] seeds[$];
        seeds = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000, {$urandom, $urandom}};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            repeat (6)
                send_request(random_request());
            wait_for_results();
        end
    endtask

    // Long output hold-off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_toggle <= ~hold_toggle;
        repeat (12)
            send_request(random_request());
        wait_for_results();
    endtask

    // Random traffic in phases, each on a fresh seed; one phase without idling
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            write_seed({$urandom, $urandom});
            if (phase == 2)
                idle_on <= 1'b0;
            repeat (PHASE_ITEMS)
                send_request(random_request());
            wait_for_results();
            idle_on <= 1'b1;
        end
    endtask

    initial begin
        reseed_generator(RESET_SEED);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_seed_loads();
        test_output_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (expected_draws.size() != 0)
            report_mismatch("results missing", 64'(expected_draws.size()), '0);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
